// File: sv/sist_pkg.sv
package sist_pkg;

  // op codes on the input channel
  localparam logic [2:0] OP_SEND_REG    = 3'd0;
  localparam logic [2:0] OP_SEND_CANCEL = 3'd1;
  localparam logic [2:0] OP_RECV_REG    = 3'd2;
  localparam logic [2:0] OP_CHECK       = 3'd3;
  localparam logic [2:0] OP_WAKEUP      = 3'd4;
  localparam logic [2:0] OP_CLEAN       = 3'd5;

  // status codes on the result channel
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_LATCHED   = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;

  // handler bit that keeps a receive entry alive across a wakeup
  localparam int KEEP_BIT = 1;

  typedef enum logic [3:0] {
    ACT_LATCH_OS,
    ACT_LATCH_PROC,
    ACT_SEND_REG,
    ACT_CANCEL,
    ACT_RECV_REG,
    ACT_CHECK,
    ACT_WAKEUP,
    ACT_CLEAN,
    ACT_BUSY
  } act_t;

  typedef struct packed {
    logic accept;
    act_t act;
    logic rd;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// File: sv/sist_ctrl.sv
module sist_ctrl import sist_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_op,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_TAIL, S_COMMIT, S_RESP} state_t;
  typedef enum logic [2:0] {
    PH_IDLE, PH_SEND, PH_RECV_PROC, PH_RECV_HANDLER, PH_CANCEL
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic   accept;
  logic   load_out;
  act_t   act;
  phase_t phase_dec;
  logic   needs_scan;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign load_out = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // decode of the incoming word against the open sequence
  always_comb begin
    act       = ACT_BUSY;
    phase_dec = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (in_op)
          OP_SEND_REG: begin
            act       = ACT_LATCH_OS;
            phase_dec = PH_SEND;
          end
          OP_SEND_CANCEL: begin
            act       = ACT_LATCH_OS;
            phase_dec = PH_CANCEL;
          end
          OP_RECV_REG: begin
            act       = ACT_LATCH_OS;
            phase_dec = PH_RECV_PROC;
          end
          OP_CHECK:  act = ACT_CHECK;
          OP_WAKEUP: act = ACT_WAKEUP;
          OP_CLEAN:  act = ACT_CLEAN;
          default:   act = ACT_BUSY;
        endcase
      end
      PH_SEND: begin
        if (in_op == OP_SEND_REG) begin
          act       = ACT_SEND_REG;
          phase_dec = PH_IDLE;
        end
      end
      PH_CANCEL: begin
        if (in_op == OP_SEND_CANCEL) begin
          act       = ACT_CANCEL;
          phase_dec = PH_IDLE;
        end
      end
      PH_RECV_PROC: begin
        if (in_op == OP_RECV_REG) begin
          act       = ACT_LATCH_PROC;
          phase_dec = PH_RECV_HANDLER;
        end
      end
      PH_RECV_HANDLER: begin
        if (in_op == OP_RECV_REG) begin
          act       = ACT_RECV_REG;
          phase_dec = PH_IDLE;
        end
      end
      default: begin
        act       = ACT_BUSY;
        phase_dec = PH_IDLE;
      end
    endcase
  end

  assign needs_scan = (act == ACT_SEND_REG) || (act == ACT_CANCEL) ||
                      (act == ACT_RECV_REG) || (act == ACT_CHECK) ||
                      (act == ACT_WAKEUP);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          phase_nxt = phase_dec;
          state_nxt = needs_scan ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL:   state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_RESP;
      S_RESP: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.accept   = accept;
  assign cmd.act      = act;
  assign cmd.rd       = (state_r == S_SCAN);
  assign cmd.commit   = (state_r == S_COMMIT);
  assign cmd.load_out = load_out;

endmodule

// File: sv/sist_dp.sv
module sist_dp import sist_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [63:0] in_data,
  input  logic [63:0] in_os_id,
  input  logic [63:0] in_proc_id,
  output logic [2:0]  out_status,
  output logic        out_found,
  output logic [7:0]  out_slot_index,
  output logic [63:0] out_handler
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [IW-1:0] idx_t;
  typedef struct packed {
    logic [63:0] os;
    logic [63:0] proc;
  } pair_t;
  typedef struct packed {
    pair_t       pair;
    logic [63:0] hnd;
  } recv_ent_t;

  // tables; an entry whose valid bit is clear reads as all zero
  pair_t     send_mem [SLOTS];
  recv_ent_t recv_mem [SLOTS];
  logic [SLOTS-1:0] send_vld_r;
  logic [SLOTS-1:0] recv_vld_r;

  logic [63:0] latched_os_r, latched_proc_r;
  logic [63:0] key_os_r, key_proc_r, hnd_r;
  act_t        act_r;
  idx_t        idx_r, rd_idx_r;
  logic        rd_vld_r;
  pair_t       rd_send_r;
  recv_ent_t   rd_recv_r;
  logic        rd_send_v_r, rd_recv_v_r;

  logic        hit_r, free_r;
  idx_t        hit_idx_r, free_idx_r;
  logic [63:0] hit_h_r;

  logic [2:0]  res_status_r;
  logic        res_found_r;
  logic [7:0]  res_slot_r;
  logic [63:0] res_handler_r;

  logic [2:0]  out_status_r;
  logic        out_found_r;
  logic [7:0]  out_slot_r;
  logic [63:0] out_handler_r;

  logic        send_tbl;
  logic [63:0] ent_os, ent_proc, ent_h;
  logic        ent_match, ent_free;

  logic        send_we, recv_we, send_clr, recv_clr;
  idx_t        wr_idx;
  logic [2:0]  cm_status;
  logic        cm_found;
  logic [7:0]  cm_slot;
  logic [63:0] cm_handler;

  assign sts.scan_last = (idx_r == idx_t'(SLOTS - 1));

  // compare stage on the registered read
  assign send_tbl = (act_r == ACT_SEND_REG) || (act_r == ACT_CANCEL) ||
                    (act_r == ACT_CHECK);
  always_comb begin
    if (send_tbl) begin
      ent_os   = rd_send_v_r ? rd_send_r.os   : '0;
      ent_proc = rd_send_v_r ? rd_send_r.proc : '0;
    end else begin
      ent_os   = rd_recv_v_r ? rd_recv_r.pair.os   : '0;
      ent_proc = rd_recv_v_r ? rd_recv_r.pair.proc : '0;
    end
    ent_h = rd_recv_v_r ? rd_recv_r.hnd : '0;
  end
  assign ent_match = (ent_os == key_os_r) && (ent_proc == key_proc_r);
  assign ent_free  = (ent_os == '0) && (ent_proc == '0);

  // writeback after the scan
  assign wr_idx = hit_r ? hit_idx_r : free_idx_r;
  always_comb begin
    send_we    = 1'b0;
    recv_we    = 1'b0;
    send_clr   = 1'b0;
    recv_clr   = 1'b0;
    cm_status  = ST_DONE;
    cm_found   = 1'b0;
    cm_slot    = '0;
    cm_handler = '0;
    if (cmd.commit) begin
      case (act_r)
        ACT_SEND_REG: begin
          if (!hit_r) begin
            if (free_r) send_we = 1'b1;
            else        cm_status = ST_NO_SLOT;
          end
        end
        ACT_CANCEL: send_clr = hit_r;
        ACT_RECV_REG: begin
          if (hit_r || free_r) recv_we = 1'b1;
          else                 cm_status = ST_NO_SLOT;
        end
        ACT_CHECK: begin
          if (hit_r) begin
            cm_found = 1'b1;
            cm_slot  = 8'(hit_idx_r);
          end else begin
            cm_status = ST_NOT_FOUND;
          end
        end
        ACT_WAKEUP: begin
          if (hit_r) begin
            cm_found   = 1'b1;
            cm_handler = hit_h_r;
            recv_clr   = !hit_h_r[KEEP_BIT];
          end else begin
            cm_status = ST_NOT_FOUND;
          end
        end
        default: cm_status = ST_DONE;
      endcase
    end
  end

  // control: valid bits and scan trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_vld_r <= '0;
      recv_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.accept) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        if (cmd.act == ACT_CLEAN) begin
          send_vld_r <= '0;
          recv_vld_r <= '0;
        end
      end else if (rd_vld_r) begin
        if (ent_match) hit_r  <= 1'b1;
        if (ent_free)  free_r <= 1'b1;
      end
      if (send_we)  send_vld_r[wr_idx] <= 1'b1;
      if (send_clr) send_vld_r[wr_idx] <= 1'b0;
      if (recv_we)  recv_vld_r[wr_idx] <= 1'b1;
      if (recv_clr) recv_vld_r[wr_idx] <= 1'b0;
    end
  end

  // payload, memories and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= cmd.act;
      idx_r <= '0;
      case (cmd.act)
        ACT_LATCH_OS:   latched_os_r   <= in_data;
        ACT_LATCH_PROC: latched_proc_r <= in_data;
        ACT_SEND_REG, ACT_CANCEL: begin
          latched_proc_r <= in_data;
          key_os_r       <= latched_os_r;
          key_proc_r     <= in_data;
        end
        ACT_RECV_REG: begin
          key_os_r   <= latched_os_r;
          key_proc_r <= latched_proc_r;
          hnd_r      <= in_data;
        end
        ACT_CHECK, ACT_WAKEUP: begin
          key_os_r   <= in_os_id;
          key_proc_r <= in_proc_id;
        end
        default: ;
      endcase
      res_found_r   <= 1'b0;
      res_slot_r    <= '0;
      res_handler_r <= '0;
      case (cmd.act)
        ACT_LATCH_OS, ACT_LATCH_PROC: res_status_r <= ST_LATCHED;
        ACT_BUSY:                     res_status_r <= ST_BUSY;
        default:                      res_status_r <= ST_DONE;
      endcase
    end

    if (cmd.rd) begin
      idx_r       <= idx_r + idx_t'(1);
      rd_idx_r    <= idx_r;
      rd_send_r   <= send_mem[idx_r];
      rd_recv_r   <= recv_mem[idx_r];
      rd_send_v_r <= send_vld_r[idx_r];
      rd_recv_v_r <= recv_vld_r[idx_r];
    end

    if (rd_vld_r) begin
      if (ent_match && !hit_r) begin
        hit_idx_r <= rd_idx_r;
        hit_h_r   <= ent_h;
      end
      if (ent_free) free_idx_r <= rd_idx_r;
    end

    if (send_we) send_mem[wr_idx] <= '{os: key_os_r, proc: key_proc_r};
    if (recv_we) recv_mem[wr_idx] <= '{pair: '{os: key_os_r, proc: key_proc_r},
                                       hnd: hnd_r};

    if (cmd.commit) begin
      res_status_r  <= cm_status;
      res_found_r   <= cm_found;
      res_slot_r    <= cm_slot;
      res_handler_r <= cm_handler;
    end

    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_found_r   <= res_found_r;
      out_slot_r    <= res_slot_r;
      out_handler_r <= res_handler_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_slot_index = out_slot_r;
  assign out_handler    = out_handler_r;

endmodule

// File: sv/soft_interrupt_slot_table.sv
// Soft-interrupt slot table: a send table of receiver (os, proc) pairs and a
// receive table of sender pairs with handler words, SLOTS entries each.
// Input channel (in_valid / in_stall): one word carries op, data, os_id and
// proc_id. Registrations and cancels are sequences of words (os, proc and,
// for receive, handler); check-send, wakeup and clean are single words.
// Result channel (out_valid / out_stall): exactly one result word per input
// word, in order, carrying status, found, slot_index and handler.
// Words that only latch, clean or are rejected go straight to the result
// load. Words that search a table read one table entry per cycle through
// the registered memory port, then compare the last entry, write back and
// load the result register.
// One word is in work at a time; in_stall is high from accept until its
// result is loaded. A new word may be taken while the previous result still
// waits on a stalled receiver; it then holds in its last step until the
// result register is free. Results never drop while out_stall is high.
// Reset empties both tables at once (per-entry valid bits) and closes any
// open sequence; no clearing pass is needed.
module soft_interrupt_slot_table import sist_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [63:0] in_data,
  input  logic [63:0] in_os_id,
  input  logic [63:0] in_proc_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_found,
  output logic [7:0]  out_slot_index,
  output logic [63:0] out_handler
);

  cmd_t cmd;   // controller to datapath
  sts_t sts;   // datapath to controller

  // sequencing, scan steps and output handshake
  sist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, scan compare, writeback and result registers
  sist_dp #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_data        (in_data),
    .in_os_id       (in_os_id),
    .in_proc_id     (in_proc_id),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_slot_index (out_slot_index),
    .out_handler    (out_handler)
  );

  // one word in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while another is in work");

  // a fresh result only ever comes from a result-register load
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("out_valid rose without a result load");

  // writeback is a single cycle per scan
  a_commit_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !cmd.commit)
    else $error("writeback repeated");

  // a hit is always reported as done
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_DONE))
    else $error("found set with a non-done status");

endmodule
